// File: hdl/clt_pkg.sv
// Shared types and constants for the command line tokenizer.
// No dependencies; every other source file imports this package.
package clt_pkg;

    typedef enum logic [2:0] {
        PH_KEYWORD = 3'd0,
        PH_ARGS    = 3'd1,
        PH_CRLF    = 3'd2,
        PH_OK      = 3'd3,
        PH_INVALID = 3'd4
    } phase_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic CMD_PARSE   = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } clt_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic       store_write;
        logic [8:0] store_index;
        logic [7:0] store_value;
        logic       clear_previous;
        logic [9:0] line_length;
        logic       first_arg_valid;
        logic [8:0] first_arg_offset;
        logic       second_arg_valid;
        logic [8:0] second_arg_offset;
    } clt_out_t;

endpackage

// File: hdl/command_line_tokenizer.sv
// Command line tokenizer: takes one command line byte (or a restart command)
// per request and returns one result per request.
//
// Input channel (s_valid/s_ready/s_data): each request carries a command bit
// and a data byte. Command 0 parses the byte; command 1 restarts the parser.
// Result channel (m_valid/m_ready/m_data): one result per request, giving the
// line buffer write (index, value, zeroing of the previous slot), the phase,
// the line length and the recorded argument start positions.
//
// A result appears on m_valid in the cycle after its request is taken.
// Throughput: one request per cycle unless results stall; the parser step is
// a single pass of compares and a counter increment feeding the result
// register, and parser state updates in the same edge that takes the request.
//
// Reset (aresetn low, synchronous): the parser returns to keyword phase with
// an empty line and no argument starts; the result register empties.
//
// Stall: while m_ready is low and a result is held, s_ready drops so no
// request is lost; s_ready rises again in the cycle the result is taken.
module command_line_tokenizer import clt_pkg::*; #(
    parameter int LINE_CAPACITY = 512
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  clt_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output clt_out_t m_data
);

    logic     step_en;
    clt_out_t step_result;

    // accept a request only when the result register can take its result
    assign step_en = s_valid && s_ready;

    clt_parser #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .in_item (s_data),
        .result  (step_result)
    );

    clt_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step_en),
        .load_data (step_result),
        .can_load  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: hdl/clt_parser.sv
// Parser state registers and the combinational step logic for one request.
// Depends on clt_pkg.
module clt_parser import clt_pkg::*; #(
    parameter int LINE_CAPACITY = 512
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step_en,
    input  clt_in_t  in_item,
    output clt_out_t result
);

    localparam int CNT_W = $clog2(LINE_CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_CAPACITY);

    phase_t           phase_reg, phase_next;
    phase_t           prior_reg, prior_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             first_vld_reg, first_vld_next;
    logic [CNT_W-1:0] first_pos_reg, first_pos_next;
    logic             second_vld_reg, second_vld_next;
    logic [CNT_W-1:0] second_pos_reg, second_pos_next;

    logic             wr;
    logic [7:0]       val;
    logic             clr_prev;
    logic [7:0]       c;
    logic [CNT_W+9:0] idx_ext, len_ext, first_ext, second_ext;

    assign c = in_item.data_byte;

    always_comb begin
        phase_next      = phase_reg;
        prior_next      = prior_reg;
        count_next      = count_reg;
        first_vld_next  = first_vld_reg;
        first_pos_next  = first_pos_reg;
        second_vld_next = second_vld_reg;
        second_pos_next = second_pos_reg;
        wr              = 1'b0;
        val             = CH_NUL;
        clr_prev        = 1'b0;

        if (in_item.command == CMD_RESTART) begin
            phase_next      = PH_KEYWORD;
            prior_next      = PH_KEYWORD;
            count_next      = '0;
            first_vld_next  = 1'b0;
            first_pos_next  = '0;
            second_vld_next = 1'b0;
            second_pos_next = '0;
        end else if (count_reg != CAP) begin
            wr         = 1'b1;
            val        = c;
            count_next = count_reg + 1'b1;
            case (phase_reg)
                PH_KEYWORD: begin
                    if (c == CH_SPACE) begin
                        prior_next = PH_KEYWORD;
                        phase_next = PH_ARGS;
                        val        = CH_NUL;
                    end else if (c == CH_CR) begin
                        phase_next = PH_CRLF;
                        val        = CH_NUL;
                    end
                end
                PH_CRLF: begin
                    if (c == CH_LF) begin
                        if (prior_reg == PH_INVALID) begin
                            // drop the invalid line silently
                            phase_next      = PH_KEYWORD;
                            count_next      = '0;
                            first_vld_next  = 1'b0;
                            first_pos_next  = '0;
                            second_vld_next = 1'b0;
                            second_pos_next = '0;
                        end else begin
                            phase_next = PH_OK;
                            val        = CH_NUL;
                            clr_prev   = (count_reg != '0);
                        end
                    end else begin
                        phase_next = PH_INVALID;
                    end
                    prior_next = PH_CRLF;
                end
                PH_ARGS: begin
                    if (c != CH_SPACE && c != CH_TAB && c != CH_CR &&
                        prior_reg == PH_KEYWORD) begin
                        if (!first_vld_reg) begin
                            first_vld_next = 1'b1;
                            first_pos_next = count_reg;
                        end else begin
                            second_vld_next = 1'b1;
                            second_pos_next = count_reg;
                        end
                        prior_next = PH_ARGS;
                    end else if (c == CH_SPACE && prior_reg == PH_ARGS) begin
                        prior_next = PH_KEYWORD;
                        val        = CH_NUL;
                    end else if (c == CH_CR) begin
                        prior_next = PH_ARGS;
                        phase_next = PH_CRLF;
                    end
                end
                PH_INVALID: begin
                    prior_next = PH_INVALID;
                    phase_next = (c == CH_CR) ? PH_CRLF : PH_INVALID;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        idx_ext    = {{10{1'b0}}, count_reg};
        len_ext    = {{10{1'b0}}, count_next};
        first_ext  = {{10{1'b0}}, first_pos_next};
        second_ext = {{10{1'b0}}, second_pos_next};

        result.status            = (in_item.command == CMD_PARSE && count_reg == CAP) ?
                                   PH_INVALID : phase_next;
        result.store_write       = wr;
        result.store_index       = wr ? idx_ext[8:0] : 9'd0;
        result.store_value       = wr ? val : CH_NUL;
        result.clear_previous    = clr_prev;
        result.line_length       = len_ext[9:0];
        result.first_arg_valid   = first_vld_next;
        result.first_arg_offset  = first_vld_next ? first_ext[8:0] : 9'd0;
        result.second_arg_valid  = second_vld_next;
        result.second_arg_offset = second_vld_next ? second_ext[8:0] : 9'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_KEYWORD;
            prior_reg      <= PH_KEYWORD;
            count_reg      <= '0;
            first_vld_reg  <= 1'b0;
            first_pos_reg  <= '0;
            second_vld_reg <= 1'b0;
            second_pos_reg <= '0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            prior_reg      <= prior_next;
            count_reg      <= count_next;
            first_vld_reg  <= first_vld_next;
            first_pos_reg  <= first_pos_next;
            second_vld_reg <= second_vld_next;
            second_pos_reg <= second_pos_next;
        end
    end

endmodule

// File: hdl/clt_out_stage.sv
// Result register with valid/ready handshake toward the receiver.
// Depends on clt_pkg.
module clt_out_stage import clt_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     load,
    input  clt_out_t load_data,
    output logic     can_load,
    output logic     m_valid,
    input  logic     m_ready,
    output clt_out_t m_data
);

    logic     valid_reg, valid_next;
    clt_out_t data_reg;

    // a new result may enter when the register is empty or drains this cycle
    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// File: tb/command_line_tokenizer_checker.sv
// Result checker for the command line tokenizer: predicts each result from the
// accepted requests and compares it with what the block returns.
// Depends on clt_pkg for the payload types, phase codes and byte constants.
`timescale 1ns / 1ps

module command_line_tokenizer_checker import clt_pkg::*; #(
    parameter int LINE_CAPACITY = 512
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  clt_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  clt_out_t m_data,
    output int       fail_count,
    output int       pending_results
);

    phase_t     line_phase;
    phase_t     prior_phase;
    logic [9:0] line_len;
    logic       first_valid;
    logic [9:0] first_start;
    logic       second_valid;
    logic [9:0] second_start;

    clt_out_t results_due[$];
    int       mismatches = 0;
    int       results_seen = 0;

    assign fail_count = mismatches;

    function automatic void clear_line();
        line_len     = '0;
        first_valid  = 1'b0;
        first_start  = '0;
        second_valid = 1'b0;
        second_start = '0;
    endfunction

    function automatic void restart_parser();
        line_phase  = PH_KEYWORD;
        prior_phase = PH_KEYWORD;
        clear_line();
    endfunction

    // Advance the parser by one request and return the result it causes.
    function automatic clt_out_t tokenize_step(input clt_in_t req);
        clt_out_t   res;
        logic [9:0] slot;
        logic [7:0] c;
        res = '0;
        c   = req.data_byte;
        if (req.command == CMD_RESTART) begin
            restart_parser();
            res.status = PH_KEYWORD;
        end else if (line_len >= LINE_CAPACITY) begin
            // full buffer: no write, no state change
            res.status = PH_INVALID;
        end else begin
            slot            = line_len;
            res.store_write = 1'b1;
            res.store_index = slot[8:0];
            res.store_value = c;
            line_len        = line_len + 10'd1;
            case (line_phase)
                PH_KEYWORD: begin
                    if (c == CH_SPACE) begin
                        prior_phase     = PH_KEYWORD;
                        line_phase      = PH_ARGS;
                        res.store_value = CH_NUL;
                    end else if (c == CH_CR) begin
                        line_phase      = PH_CRLF;
                        res.store_value = CH_NUL;
                    end
                end
                PH_CRLF: begin
                    if (c == CH_LF) begin
                        if (prior_phase == PH_INVALID) begin
                            line_phase = PH_KEYWORD;
                            clear_line();
                        end else begin
                            line_phase         = PH_OK;
                            res.store_value    = CH_NUL;
                            res.clear_previous = (slot != 10'd0);
                        end
                    end else begin
                        line_phase = PH_INVALID;
                    end
                    prior_phase = PH_CRLF;
                end
                PH_ARGS: begin
                    if (c != CH_SPACE && c != CH_TAB && c != CH_CR
                            && prior_phase == PH_KEYWORD) begin
                        if (!first_valid) begin
                            first_valid = 1'b1;
                            first_start = slot;
                        end else begin
                            second_valid = 1'b1;
                            second_start = slot;
                        end
                        prior_phase = PH_ARGS;
                    end else if (c == CH_SPACE && prior_phase == PH_ARGS) begin
                        prior_phase     = PH_KEYWORD;
                        res.store_value = CH_NUL;
                    end else if (c == CH_CR) begin
                        prior_phase = PH_ARGS;
                        line_phase  = PH_CRLF;
                    end
                end
                PH_INVALID: begin
                    prior_phase = PH_INVALID;
                    if (c == CH_CR) begin
                        line_phase = PH_CRLF;
                    end else begin
                        line_phase = PH_INVALID;
                    end
                end
                default: ;
            endcase
            res.status = line_phase;
        end
        res.line_length       = line_len;
        res.first_arg_valid   = first_valid;
        res.first_arg_offset  = first_valid ? first_start[8:0] : 9'd0;
        res.second_arg_valid  = second_valid;
        res.second_arg_offset = second_valid ? second_start[8:0] : 9'd0;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [9:0] want,
                               input logic [9:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d: %s expected %0d, got %0d",
                         results_seen, name, want, got);
            end
        end
    endtask

    task automatic compare_result(input clt_out_t want, input clt_out_t got);
        check_field("status", 10'(want.status), 10'(got.status));
        check_field("store_write", 10'(want.store_write), 10'(got.store_write));
        check_field("store_index", 10'(want.store_index), 10'(got.store_index));
        check_field("store_value", 10'(want.store_value), 10'(got.store_value));
        check_field("clear_previous", 10'(want.clear_previous),
                    10'(got.clear_previous));
        check_field("line_length", want.line_length, got.line_length);
        check_field("first_arg_valid", 10'(want.first_arg_valid),
                    10'(got.first_arg_valid));
        check_field("first_arg_offset", 10'(want.first_arg_offset),
                    10'(got.first_arg_offset));
        check_field("second_arg_valid", 10'(want.second_arg_valid),
                    10'(got.second_arg_valid));
        check_field("second_arg_offset", 10'(want.second_arg_offset),
                    10'(got.second_arg_offset));
    endtask

    // Compare before predicting so a result never pairs with the request
    // taken at the same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_parser();
            results_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d arrived with none outstanding: %p",
                                 results_seen, m_data);
                    end
                end else begin
                    compare_result(results_due.pop_front(), m_data);
                end
            end
            if (s_valid && s_ready) begin
                results_due.push_back(tokenize_step(s_data));
            end
        end
        pending_results <= results_due.size();
    end

endmodule

// File: tb/command_line_tokenizer_test.sv
// Top of the command line tokenizer testbench: clock, reset, request stimulus,
// random result stalls and the verdict.
// Depends on clt_pkg, command_line_tokenizer and command_line_tokenizer_checker.
`timescale 1ns / 1ps

module command_line_tokenizer_test;
    import clt_pkg::*;

    localparam int LINE_CAPACITY = 512;
    localparam int ITEM_TARGET   = 1250;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    clt_in_t  s_data;
    logic     m_valid;
    logic     m_ready = 1'b0;
    clt_out_t m_data;

    int fail_count;
    int pending_results;

    // Idle rates in percent of cycles; they change as the run goes on.
    int tx_idle_pct   = 8;
    int rx_idle_pct   = 71;
    int requests_sent = 0;

    command_line_tokenizer #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    command_line_tokenizer_checker #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: drop ready at random, at the current receiver idle rate.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Pick a byte that can sit inside a keyword or an argument: never a
    // space, tab, CR or LF, so it always starts or extends a word.
    function automatic logic [7:0] word_byte();
        logic [7:0] b;
        if ($urandom_range(3) == 0) begin
            b = 8'($urandom);
        end else begin
            b = 8'($urandom_range(8'h7E, 8'h21));
        end
        if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) begin
            b = 8'h5F;
        end
        return b;
    endfunction

    // Pick a byte biased toward the characters the parser reacts to.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(7))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            3:       return CH_LF;
            4:       return CH_NUL;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one request and hold it until the block takes it. The sender
    // may idle first; valid only drops during such an idle gap.
    task automatic send_request(input logic cmd, input logic [7:0] b);
        clt_in_t req;
        req.command   = cmd;
        req.data_byte = b;
        // Swap the idle rates after a third of the run, stop idling after two.
        if (requests_sent == ITEM_TARGET / 3) begin
            tx_idle_pct = 71;
            rx_idle_pct = 8;
        end else if (requests_sent == 2 * ITEM_TARGET / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_request(CMD_PARSE, b);
    endtask

    task automatic send_restart();
        send_request(CMD_RESTART, 8'($urandom));
    endtask

    task automatic send_word(input int len);
        repeat (len) send_byte(word_byte());
    endtask

    initial begin
        int kind;
        int lines_done;
        int fills_done;
        int arg_count;
        lines_done = 0;
        fills_done = 0;

        s_valid <= 1'b0;
        s_data  <= '0;
        aresetn <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: a full command with a tab, doubled separators and a
        // second argument, then a byte stored after completion.
        send_request(CMD_RESTART, 8'hFF);
        send_byte("G");
        send_byte("E");
        send_byte("T");
        send_byte(CH_SPACE);
        send_byte("a");
        send_byte(CH_TAB);
        send_byte(CH_SPACE);
        send_byte(CH_SPACE);
        send_byte("b");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(8'hFF);
        // Bare CR LF ends a line from the keyword phase.
        send_request(CMD_RESTART, 8'h00);
        send_byte(CH_CR);
        send_byte(CH_LF);
        // Junk after CR makes the line invalid; its CR LF drops it silently
        // and the next byte lands at position zero again.
        send_restart();
        send_byte("x");
        send_byte(CH_CR);
        send_byte(CH_NUL);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte("k");

        // Random part, built from whole lines.
        while (requests_sent < ITEM_TARGET) begin
            kind = $urandom_range(99);
            if ((fills_done == 0 && lines_done == 6) ||
                (fills_done < 2 && kind < 2 &&
                 requests_sent + LINE_CAPACITY < ITEM_TARGET)) begin
                // Fill the buffer to capacity with many arguments, then hit
                // the full buffer with line ends and noise.
                send_restart();
                repeat (LINE_CAPACITY) begin
                    if ($urandom_range(4) == 0) begin
                        send_byte(CH_SPACE);
                    end else begin
                        send_byte(word_byte());
                    end
                end
                send_byte(CH_CR);
                send_byte(CH_LF);
                repeat (4) send_byte(noise_byte());
                send_restart();
                fills_done++;
            end else if (kind < 70) begin
                // Well-formed command line with random content.
                if ($urandom_range(9) != 0) begin
                    send_restart();
                end
                send_word($urandom_range(6, 1));
                arg_count = $urandom_range(4);
                for (int a = 0; a < arg_count; a++) begin
                    repeat ($urandom_range(2, 1)) send_byte(CH_SPACE);
                    if ($urandom_range(5) == 0) begin
                        send_byte(CH_TAB);
                    end
                    send_word($urandom_range(5, 1));
                end
                if ($urandom_range(3) == 0) begin
                    send_byte(CH_SPACE);
                end
                send_byte(CH_CR);
                send_byte(CH_LF);
                repeat ($urandom_range(2)) send_byte(noise_byte());
            end else if (kind < 85) begin
                // Broken line: junk after CR, then a closing CR LF drops it.
                if ($urandom_range(1) == 0) begin
                    send_restart();
                end
                send_word($urandom_range(4, 1));
                if ($urandom_range(1) == 0) begin
                    send_byte(CH_SPACE);
                    send_word($urandom_range(3, 1));
                end
                send_byte(CH_CR);
                send_byte(word_byte());
                send_word($urandom_range(3));
                if ($urandom_range(2) == 0) begin
                    send_byte(CH_CR);
                    send_byte(word_byte());
                end
                send_byte(CH_CR);
                send_byte(CH_LF);
                send_word($urandom_range(2));
            end else begin
                // Noise bytes, sometimes from a fresh parser.
                if ($urandom_range(2) == 0) begin
                    send_restart();
                end
                repeat ($urandom_range(12, 1)) send_byte(noise_byte());
            end
            lines_done++;
        end
        s_valid <= 1'b0;

        // Drain: let outstanding results arrive, then wait quietly before the verdict.
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        if (fail_count == 0 && pending_results == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: command_line_tokenizer.f
hdl/clt_pkg.sv
hdl/clt_parser.sv
hdl/clt_out_stage.sv
hdl/command_line_tokenizer.sv
tb/command_line_tokenizer_checker.sv
tb/command_line_tokenizer_test.sv
